// File: src/mbps_pkg.sv
// Package for the masked byte pattern scanner: item types, register indexes, defaults.
package mbps_pkg;

    localparam int DEF_MAX_PATTERN_BYTES = 16;
    localparam int DEF_OFFSET_BITS       = 32;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int LEN_W      = 5;
    localparam int LANE_BITS  = 128;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MASKS_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MASKS_HIGH = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [31:0] match_offset;
    } out_item_t;

endpackage

// File: src/mbps_match.sv
// Parallel masked compare of the pattern against the newest byte and the byte window.
module mbps_match
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES
)
(
    input  logic [7:0]                         cur_byte,
    input  logic [MAX_PATTERN_BYTES-2:0][7:0]  window,
    input  logic [LEN_W-1:0]                   len,
    input  logic [LANE_BITS-1:0]               pattern,
    input  logic [LANE_BITS-1:0]               masks,
    output logic                               lanes_ok
);

    logic [MAX_PATTERN_BYTES-1:0][7:0] full;
    logic [MAX_PATTERN_BYTES-1:0]      lane_ok;

    always_comb
    begin
        full[0] = cur_byte;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++)
        begin
            full[k] = window[k-1];
        end
    end

    // pattern byte i lines up with the byte (len-1-i) places back
    always_comb
    begin
        logic [7:0] b;
        logic [7:0] p;
        logic [7:0] m;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            b = 8'h00;
            for (int k = 0; k < MAX_PATTERN_BYTES; k++)
            begin
                if (LEN_W'(k) == len - LEN_W'(1) - LEN_W'(i))
                begin
                    b = full[k];
                end
            end
            p = pattern[8*i +: 8];
            m = masks[8*i +: 8];
            lane_ok[i] = (LEN_W'(i) >= len) || ((b & m) == (p & m));
        end
    end

    assign lanes_ok = &lane_ok;

endmodule

// File: src/masked_byte_pattern_scanner.sv
// Top level of the masked byte pattern scanner.
//
//  channel   direction  handshake            payload
//  in        into       in_valid / in_ready  in_data  (in_item_t)
//  out       out of     out_valid/out_ready  out_data (out_item_t)
//  cfg       into       cfg_we               cfg_index, cfg_wdata
//
// One item per cycle sustained while out_ready is not held low; an item enters the input register at its accept edge
// and its result, if any, is written to the result register when the item advances out of the input register.
// The compare path is one masked byte compare per pattern lane plus an AND tree.
// Reset clears the scan state, the handshake flags, the pattern bytes and masks, and loads pattern_length = 1.
// A result held by out_ready low stalls the input register, then in_ready.
module masked_byte_pattern_scanner
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
    parameter int OFFSET_BITS       = DEF_OFFSET_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int WD = MAX_PATTERN_BYTES - 1;
    localparam int OW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
    localparam logic [LEN_W-1:0]       MAX_LEN   = LEN_W'(MAX_PATTERN_BYTES);
    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

    logic [LEN_W-1:0]      pattern_length_reg;
    logic [CFG_DATA_W-1:0] pattern_bytes_low_reg;
    logic [CFG_DATA_W-1:0] pattern_bytes_high_reg;
    logic [CFG_DATA_W-1:0] pattern_masks_low_reg;
    logic [CFG_DATA_W-1:0] pattern_masks_high_reg;

    logic                 in_valid_reg;
    in_item_t             in_item_reg;
    logic                 out_valid_reg;
    out_item_t            out_item_reg;
    out_item_t            out_item_next;

    logic [WD-1:0][7:0]     window_reg;
    logic [WD-1:0][7:0]     window_next;
    logic [OFFSET_BITS-1:0] bytes_seen_reg;
    logic [OFFSET_BITS-1:0] bytes_seen_next;
    logic                   scan_done_reg;
    logic                   scan_done_next;

    logic                   advance;
    logic                   emit;
    logic                   hit;
    logic                   lanes_ok;
    logic [LEN_W-1:0]       len;
    logic [OFFSET_BITS-1:0] seen;
    logic [OFFSET_BITS-1:0] start;
    logic [OW-1:0]          start_ext;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg     <= LEN_W'(1);
            pattern_bytes_low_reg  <= '0;
            pattern_bytes_high_reg <= '0;
            pattern_masks_low_reg  <= '0;
            pattern_masks_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LENGTH:     pattern_length_reg     <= cfg_wdata[LEN_W-1:0];
                CFG_PATTERN_BYTES_LOW:  pattern_bytes_low_reg  <= cfg_wdata;
                CFG_PATTERN_BYTES_HIGH: pattern_bytes_high_reg <= cfg_wdata;
                CFG_PATTERN_MASKS_LOW:  pattern_masks_low_reg  <= cfg_wdata;
                CFG_PATTERN_MASKS_HIGH: pattern_masks_high_reg <= cfg_wdata;
                default:                ;
            endcase
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign len  = (pattern_length_reg > MAX_LEN) ? MAX_LEN : pattern_length_reg;
    assign seen = (bytes_seen_reg == COUNT_MAX) ? COUNT_MAX
                                                : bytes_seen_reg + OFFSET_BITS'(1);

    mbps_match #(
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
    ) u_match (
        .cur_byte (in_item_reg.data_byte),
        .window   (window_reg),
        .len      (len),
        .pattern  ({pattern_bytes_high_reg, pattern_bytes_low_reg}),
        .masks    ({pattern_masks_high_reg, pattern_masks_low_reg}),
        .lanes_ok (lanes_ok)
    );

    assign hit       = (len != '0) && (seen >= OFFSET_BITS'(len)) && lanes_ok;
    assign start     = seen - OFFSET_BITS'(len);
    assign start_ext = OW'(start);

    always_comb
    begin
        window_next     = window_reg;
        bytes_seen_next = bytes_seen_reg;
        scan_done_next  = scan_done_reg;
        emit            = 1'b0;
        out_item_next   = '0;
        if (!scan_done_reg)
        begin
            if (hit)
            begin
                emit                       = 1'b1;
                out_item_next.found        = 1'b1;
                out_item_next.match_offset = start_ext[31:0];
                scan_done_next             = 1'b1;
            end
            else
            begin
                window_next[0] = in_item_reg.data_byte;
                for (int k = 1; k < WD; k++)
                begin
                    window_next[k] = window_reg[k-1];
                end
                bytes_seen_next = seen;
                emit            = in_item_reg.last_byte;
            end
        end
        if (in_item_reg.last_byte)
        begin
            window_next     = '0;
            bytes_seen_next = '0;
            scan_done_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            window_reg     <= '0;
            bytes_seen_reg <= '0;
            scan_done_reg  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                window_reg     <= window_next;
                bytes_seen_reg <= bytes_seen_next;
                scan_done_reg  <= scan_done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
        if (advance && emit)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

// File: src/mbps_check.sv
// Port-level checks for the masked byte pattern scanner, bound to the top level.
module mbps_check
    import mbps_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result item changed while stalled");

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.match_offset == 32'd0)
        else $error("not-found item carries an offset");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result item during reset");

endmodule

bind masked_byte_pattern_scanner mbps_check u_mbps_check (.*);

// File: verif/testbench.sv
// Testbench for the masked byte pattern scanner: directed and random byte regions checked against a predictor.
module testbench
    import mbps_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS  = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int LANES         = DEF_MAX_PATTERN_BYTES;

    localparam logic [7:0] MASK_EXACT       = 8'hFF;
    localparam logic [7:0] MASK_HIGH_NIBBLE = 8'hF0;
    localparam logic [7:0] MASK_LOW_NIBBLE  = 8'h0F;
    localparam logic [7:0] MASK_WILDCARD    = 8'h00;

    class scan_predictor;
        localparam int WINDOW_DEPTH = DEF_MAX_PATTERN_BYTES - 1;

        logic [LEN_W-1:0]           pattern_len;
        logic [LANE_BITS-1:0]       pattern_bytes;
        logic [LANE_BITS-1:0]       pattern_masks;
        logic [7:0]                 recent [WINDOW_DEPTH];
        logic [DEF_OFFSET_BITS-1:0] seen;
        bit                         matched;
        out_item_t                  expected_reports [$];
        int                         errors;

        function new();
            pattern_len   = 1;
            pattern_bytes = '0;
            pattern_masks = '0;
            errors        = 0;
            clear_region();
        endfunction

        function void clear_region();
            foreach (recent[k])
                recent[k] = '0;
            seen    = '0;
            matched = 1'b0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_PATTERN_LENGTH:     pattern_len = val[LEN_W-1:0];
                CFG_PATTERN_BYTES_LOW:  pattern_bytes[63:0] = val;
                CFG_PATTERN_BYTES_HIGH: pattern_bytes[127:64] = val;
                CFG_PATTERN_MASKS_LOW:  pattern_masks[63:0] = val;
                CFG_PATTERN_MASKS_HIGH: pattern_masks[127:64] = val;
                default: ;
            endcase
        endfunction

        function void queue_report(out_item_t rep);
            expected_reports = {expected_reports, rep};
        endfunction

        // returns 1 when the byte was compared, 0 when ignored after a match
        function bit take_byte(in_item_t it);
            int                         eff;
            bit                         hit;
            bit                         compared;
            logic [DEF_OFFSET_BITS-1:0] seen_next;
            logic [7:0]                 b;
            logic [7:0]                 m;
            out_item_t                  rep;
            compared = !matched;
            if (!matched)
            begin
                eff = (pattern_len > LANES) ? LANES : int'(pattern_len);
                seen_next = (seen == '1) ? seen : seen + 1'b1;
                if (eff > 0 && seen_next >= eff)
                begin
                    hit = 1'b1;
                    for (int i = 0; i < eff; i++)
                    begin
                        b = (i == eff - 1) ? it.data_byte : recent[eff - 2 - i];
                        m = pattern_masks[8*i +: 8];
                        if ((b & m) != (pattern_bytes[8*i +: 8] & m))
                            hit = 1'b0;
                    end
                    if (hit)
                    begin
                        rep.found        = 1'b1;
                        rep.match_offset = seen_next - DEF_OFFSET_BITS'(eff);
                        queue_report(rep);
                        matched = 1'b1;
                    end
                end
                if (!matched)
                begin
                    for (int k = WINDOW_DEPTH - 1; k > 0; k--)
                        recent[k] = recent[k-1];
                    recent[0] = it.data_byte;
                    seen      = seen_next;
                    if (it.last_byte)
                    begin
                        rep.found        = 1'b0;
                        rep.match_offset = '0;
                        queue_report(rep);
                    end
                end
            end
            if (it.last_byte)
                clear_region();
            return compared;
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns  mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_report(out_item_t got);
            out_item_t exp;
            if (expected_reports.size() == 0)
            begin
                report_mismatch($sformatf("unexpected report found=%0b offset=%0d",
                                          got.found, got.match_offset));
                return;
            end
            exp = expected_reports.pop_front();
            if (got.found !== exp.found)
                report_mismatch($sformatf("found %0b, expected %0b", got.found, exp.found));
            if (got.match_offset !== exp.match_offset)
                report_mismatch($sformatf("match_offset %0d, expected %0d",
                                          got.match_offset, exp.match_offset));
        endtask
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b1;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    scan_predictor scan_pred = new();

    int tx_idle_pct = 28;
    int rx_idle_pct = 47;
    int items_sent  = 0;

    logic [LEN_W-1:0]     cur_len;
    logic [LANE_BITS-1:0] cur_pat;
    logic [LANE_BITS-1:0] cur_msk;

    masked_byte_pattern_scanner u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            scan_pred.check_report(out_data);
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial
    begin
        #2ms;
        $display("** masked_byte_pattern_scanner: FAILED **");
        $finish;
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        in_item_t it;
        int       gap;
        it.data_byte = value;
        it.last_byte = last;
        gap = 0;
        while (gap < 24 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        void'(scan_pred.take_byte(it));
        items_sent++;
    endtask

    // hold the sender until every pending report is out and the pipe is empty
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (scan_pred.expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        scan_pred.write_register(idx, val);
    endtask

    task automatic load_pattern(input logic [CFG_DATA_W-1:0] len_word,
                                input logic [CFG_DATA_W-1:0] pb_lo, pb_hi, pm_lo, pm_hi);
        write_reg(CFG_PATTERN_LENGTH, len_word);
        write_reg(CFG_PATTERN_BYTES_LOW, pb_lo);
        write_reg(CFG_PATTERN_BYTES_HIGH, pb_hi);
        write_reg(CFG_PATTERN_MASKS_LOW, pm_lo);
        write_reg(CFG_PATTERN_MASKS_HIGH, pm_hi);
        if ($urandom_range(5) == 0)
            write_reg(CFG_IDX_W'(CFG_PATTERN_MASKS_HIGH + 1 + $urandom_range(2)),
                      {$urandom, $urandom});
        cfg_we  <= 1'b0;
        cur_len = len_word[LEN_W-1:0];
        cur_pat = {pb_hi, pb_lo};
        cur_msk = {pm_hi, pm_lo};
    endtask

    task automatic load_random_pattern();
        logic [CFG_DATA_W-1:0] len_word;
        logic [LANE_BITS-1:0]  pat;
        logic [LANE_BITS-1:0]  msk;
        len_word = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       len_word[LEN_W-1:0] = '0;
            1:       len_word[LEN_W-1:0] = LEN_W'(1);
            2:       len_word[LEN_W-1:0] = LEN_W'(LANES);
            3:       len_word[LEN_W-1:0] = LEN_W'($urandom_range(LANES + 1, 31));
            4:       len_word[LEN_W-1:0] = LEN_W'($urandom_range(7, LANES - 1));
            default: len_word[LEN_W-1:0] = LEN_W'($urandom_range(2, 6));
        endcase
        pat = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(15))
            0:       pat = '0;
            1:       pat = '1;
            default: ;
        endcase
        for (int i = 0; i < LANES; i++)
        begin
            case ($urandom_range(9))
                0, 1, 2: msk[8*i +: 8] = MASK_EXACT;
                3, 4:    msk[8*i +: 8] = MASK_HIGH_NIBBLE;
                5, 6:    msk[8*i +: 8] = MASK_LOW_NIBBLE;
                7, 8:    msk[8*i +: 8] = MASK_WILDCARD;
                default: msk[8*i +: 8] = 8'($urandom);
            endcase
        end
        case ($urandom_range(19))
            0:       msk = '1;
            1:       msk = '0;
            default: ;
        endcase
        load_pattern(len_word, pat[63:0], pat[127:64], msk[63:0], msk[127:64]);
    endtask

    // one region, often carrying the pattern with random don't-care bits
    task automatic send_region();
        int         rlen;
        int         eff;
        int         at;
        int         lane_sel;
        bit         left_open;
        logic [7:0] b;
        logic [7:0] m;
        rlen = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
        eff  = (cur_len > LANES) ? LANES : int'(cur_len);
        at   = -1;
        left_open = ($urandom_range(7) == 0);
        if (eff > 0 && eff <= rlen && $urandom_range(9) < 6)
            at = $urandom_range(0, rlen - eff);
        for (int k = 0; k < rlen; k++)
        begin
            if (at >= 0 && k >= at && k < at + eff)
            begin
                m = cur_msk[8*(k-at) +: 8];
                b = (cur_pat[8*(k-at) +: 8] & m) | (8'($urandom) & ~m);
            end
            else if (eff > 0 && $urandom_range(3) == 0)
            begin
                lane_sel = $urandom_range(0, eff - 1);
                b = cur_pat[8*lane_sel +: 8] ^ (8'd1 << $urandom_range(7));
            end
            else
                b = 8'($urandom);
            send_byte(b, (k == rlen - 1) && !left_open);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        cur_len = 1;
        cur_pat = '0;
        cur_msk = '0;

        // reset pattern: one wildcard byte, later bytes of the region ignored
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_drain();

        // exact, high nibble, low nibble and wildcard lanes; junk above length bits
        load_pattern(64'hFFFF_FFFF_FFFF_FFE4, 64'hFFFF_FFFF_7856_3412, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'hFFFF_FFFF_000F_F0FF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h3F, 1'b0);
        send_byte(8'hE6, 1'b0);
        send_byte(8'h99, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
        wait_drain();

        // zero length never matches
        load_pattern(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0);
        send_byte(8'hFF, 1'b1);
        for (int k = 0; k < 8; k++)
            send_byte(8'(k), 1'b0);
        wait_drain();

        // length above maximum, pattern changed mid region, odd mask on one lane
        load_pattern(64'd20, 64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_3908,
                     64'hFFFF_FFFF_FFFF_FFFF, 64'h0F0F_0F0F_0F0F_3C0F);
        for (int k = 8; k < LANES; k++)
            send_byte(8'hF0 | 8'(k), k == LANES - 1);
        wait_drain();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent < RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 28;
                rx_idle_pct = 47;
            end
            else if (items_sent < 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 47;
                rx_idle_pct = 28;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            wait_drain();
            load_random_pattern();
            repeat ($urandom_range(1, 5))
            begin
                send_region();
                if ($urandom_range(9) == 0)
                    wait_drain();
            end
        end
        wait_drain();

        if (scan_pred.errors == 0)
            $display("** masked_byte_pattern_scanner: PASSED **");
        else
            $display("** masked_byte_pattern_scanner: FAILED **");
        $finish;
    end
endmodule
